@@ rtl/signed_radix_to_text_assert.svh @@
// Assertion macros used by the checker file of this block.
// Each macro checks one implication on the rising clock edge,
// with the check held off while reset is asserted.
`ifndef SIGNED_RADIX_TO_TEXT_ASSERT_SVH
`define SIGNED_RADIX_TO_TEXT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/srt_pkg.sv @@
`timescale 1ns / 1ps

package srt_pkg;

    // Sizes of the number and of the digit store.
    localparam int VALUE_W    = 32;
    localparam int MAX_DIGITS = 32;
    localparam int MAX_RADIX  = 16;
    localparam int DIGIT_W    = $clog2(MAX_RADIX);
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W     = $clog2(VALUE_W);
    localparam int RADIX_W    = 5;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CHAR_W     = 8;

    // Fixed characters.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Radix limits applied to the configured value.
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_TOP = 5'd16;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI  = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RST     = 5'd8;
    localparam logic [CFG_W-1:0]   ALPHA_LOW_RST = 64'h3736353433323130;
    localparam logic [CFG_W-1:0]   ALPHA_HI_RST  = 64'h0;

    // Source of the character loaded into the output register.
    typedef enum logic [1:0] {
        SEL_ZERO  = 2'd0,
        SEL_MINUS = 2'd1,
        SEL_GLYPH = 2'd2
    } out_sel_t;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ZERO  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_DIGIT = 7'b0001000,
        ST_SIGN  = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     push;
        logic     read;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_zero;
        logic negative;
        logic div_last;
        logic quot_zero;
        logic cnt_zero;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/srt_ctrl.sv @@
`timescale 1ns / 1ps

module srt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  srt_pkg::sts_t sts,
    output srt_pkg::cmd_t cmd
);
    import srt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencing: divide once per digit, then read the stack back top down.
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.out_sel = SEL_GLYPH;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_zero ? ST_ZERO : ST_DIV;
                end
            end
            ST_ZERO: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_ZERO;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                cmd.push = 1'b1;
                if (sts.quot_zero) begin
                    state_next = sts.negative ? ST_SIGN : ST_READ;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_SIGN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_MINUS;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_GLYPH;
                    state_next   = sts.cnt_zero ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/srt_dp.sv @@
`timescale 1ns / 1ps

module srt_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [srt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srt_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic signed [srt_pkg::VALUE_W-1:0] s_value,
    input  srt_pkg::cmd_t                  cmd,
    output srt_pkg::sts_t                  sts,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [srt_pkg::CHAR_W-1:0]     m_character,
    output logic                           m_last
);
    import srt_pkg::*;

    logic [RADIX_W-1:0]   radix_reg;
    logic [CFG_W-1:0]     alpha_low_reg;
    logic [CFG_W-1:0]     alpha_hi_reg;
    logic [RADIX_W-1:0]   eff_radix;

    logic [VALUE_W-1:0]   quot_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   rem_next;
    logic [STEP_W-1:0]    step_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_dec;
    logic [DIGIT_W:0]     rem_shift;
    logic                 quot_bit;

    logic [DIGIT_W-1:0]   stack_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]   rd_data_reg;

    logic [2*CFG_W-1:0]   alphabet;
    logic [CHAR_W-1:0]    glyph;
    logic [CHAR_W-1:0]    char_next;

    logic                 valid_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;
    logic                 out_free;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg     <= RADIX_RST;
            alpha_low_reg <= ALPHA_LOW_RST;
            alpha_hi_reg  <= ALPHA_HI_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RADIX:     radix_reg     <= cfg_wdata[RADIX_W-1:0];
                CFG_ALPHA_LOW: alpha_low_reg <= cfg_wdata;
                CFG_ALPHA_HI:  alpha_hi_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Clamp the configured radix to the supported range.
    always_comb begin
        eff_radix = radix_reg;
        if (radix_reg < RADIX_MIN) begin
            eff_radix = RADIX_MIN;
        end else if (radix_reg > RADIX_TOP) begin
            eff_radix = RADIX_TOP;
        end
    end

    // One restoring division step: shift in the next dividend bit and
    // subtract the radix when it fits.
    assign rem_shift = {rem_reg, quot_reg[VALUE_W-1]};
    assign quot_bit  = (rem_shift >= eff_radix);

    always_comb begin
        if (quot_bit) begin
            rem_next = DIGIT_W'(rem_shift - eff_radix);
        end else begin
            rem_next = rem_shift[DIGIT_W-1:0];
        end
    end

    assign cnt_dec = cnt_reg - CNT_W'(1);

    // Division and digit counting.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quot_reg <= '0;
            rem_reg  <= '0;
            step_reg <= '0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.load) begin
            neg_reg  <= s_value[VALUE_W-1];
            quot_reg <= s_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(s_value))
                                           : VALUE_W'(s_value);
            rem_reg  <= '0;
            step_reg <= '0;
            cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            quot_reg <= {quot_reg[VALUE_W-2:0], quot_bit};
            rem_reg  <= rem_next;
            step_reg <= step_reg + STEP_W'(1);
        end else if (cmd.push) begin
            rem_reg <= '0;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end else if (cmd.read) begin
            cnt_reg <= cnt_dec;
        end
    end

    // Digit stack, least significant digit at the bottom.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stack_mem[cnt_reg[ADDR_W-1:0]] <= rem_reg;
        end
        if (cmd.read) begin
            rd_data_reg <= stack_mem[cnt_dec[ADDR_W-1:0]];
        end
    end

    // Glyph lookup and output character choice.
    assign alphabet = {alpha_hi_reg, alpha_low_reg};
    assign glyph    = alphabet[{rd_data_reg, 3'b000} +: CHAR_W];

    always_comb begin
        case (cmd.out_sel)
            SEL_ZERO:  char_next = CHAR_ZERO;
            SEL_MINUS: char_next = CHAR_MINUS;
            SEL_GLYPH: char_next = glyph;
            default:   char_next = glyph;
        endcase
    end

    assign out_free = !valid_reg || m_ready;

    // Output register; the next beat loads as the current one is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            char_reg <= char_next;
            last_reg <= (cmd.out_sel != SEL_MINUS) && (cnt_reg == '0);
        end
    end

    assign m_valid     = valid_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

    // Status to the controller.
    assign sts.in_zero   = (s_value == '0);
    assign sts.negative  = neg_reg;
    assign sts.div_last  = (step_reg == STEP_W'(VALUE_W - 1));
    assign sts.quot_zero = (quot_reg == '0);
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.out_free  = out_free;

endmodule

@@ rtl/signed_radix_to_text.sv @@
`timescale 1ns / 1ps

// Converts one signed 32-bit value per input beat into its text in a
// configured radix of 2 to 16, sent as one character per output beat, most
// significant digit first, with m_last on the final character; negative
// values start with '-', and zero is always the single character '0'. Each
// digit comes from a 32-step restoring division by the radix, one quotient
// bit per cycle, after which the remainder is pushed onto the digit stack.
// Each digit character is then made by a stack read, then an output
// register load, once the output side is ready. Input is accepted only
// between numbers, including while the final character still waits to be
// taken. Configuration (0: radix, 1: alphabet digits 0-7, 2: alphabet
// digits 8-15, digit 0 in the low byte) must be written only while the
// block is idle; the block itself does not enforce this.
module signed_radix_to_text (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_character,
    output logic                m_last
);
    import srt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    srt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    srt_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_value     (s_value),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

@@ rtl/srt_checker.sv @@
`timescale 1ns / 1ps

`include "signed_radix_to_text_assert.svh"

module srt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [7:0]         m_character,
    input logic               m_last
);

    // A stalled output beat keeps its character and end marker.
    `SRT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_character) && $stable(m_last), "output beat changed while stalled")

    // Taking a number leaves the input not ready in the cycle after it is taken.
    `SRT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input ready right after an accepted beat")

    // While a number's text is unfinished, no new number is taken.
    `SRT_ASSERT_SAME(a_no_overlap, aclk, aresetn, m_valid && !m_last, !s_ready, "input ready before the final character")

endmodule

bind signed_radix_to_text srt_checker u_srt_checker (.*);
